// ===== rtl/core/nrth_pkg.sv =====
// Shared types, constants and micro-program of the nearest ray/triangle hit unit.
package nrth_pkg;

   localparam int WORD_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int DIR_W     = 18;
   localparam int DIST_W    = 31;
   localparam int ID_W      = 16;
   localparam int TERM_W    = 2 * WORD_W - FRAC_BITS;
   localparam int ACC_W     = TERM_W + 2;
   localparam int DVD_W     = WORD_W + FRAC_BITS;
   localparam int STEP_W    = 6;

   localparam logic signed [WORD_W-1:0] ONE_Q = WORD_W'(1) <<< FRAC_BITS;
   localparam logic [DIST_W-1:0] START_RESET = DIST_W'(11351169);

   localparam logic [STEP_W-1:0] STEP_FIN   = STEP_W'(49);
   localparam logic [STEP_W-1:0] STEP_POINT = STEP_W'(50);

   typedef struct packed {
      logic signed [WORD_W-1:0] hub_x;
      logic signed [WORD_W-1:0] hub_y;
      logic signed [WORD_W-1:0] hub_z;
      logic signed [WORD_W-1:0] first_x;
      logic signed [WORD_W-1:0] first_y;
      logic signed [WORD_W-1:0] first_z;
      logic signed [WORD_W-1:0] second_x;
      logic signed [WORD_W-1:0] second_y;
      logic signed [WORD_W-1:0] second_z;
      logic [ID_W-1:0]          hub_id;
      logic                     last_triangle;
   } req_word_type;

   typedef struct packed {
      logic                     found;
      logic [ID_W-1:0]          nearest_id;
      logic [DIST_W-1:0]        hit_t;
      logic signed [WORD_W-1:0] point_x;
      logic signed [WORD_W-1:0] point_y;
      logic signed [WORD_W-1:0] point_z;
   } rsp_word_type;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X       = 3'd0,
      CSR_ORIGIN_Y       = 3'd1,
      CSR_ORIGIN_Z       = 3'd2,
      CSR_DIR_X          = 3'd3,
      CSR_DIR_Y          = 3'd4,
      CSR_DIR_Z          = 3'd5,
      CSR_START_DISTANCE = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      UK_TERM, UK_DIV, UK_TDET, UK_TU, UK_TV, UK_TT, UK_FIN, UK_OUT
   } uop_kind_type;

   typedef enum logic [4:0] {
      SRC_HX, SRC_HY, SRC_HZ, SRC_AX, SRC_AY, SRC_AZ, SRC_BX, SRC_BY, SRC_BZ,
      SRC_OX, SRC_OY, SRC_OZ, SRC_DX, SRC_DY, SRC_DZ,
      SRC_E1X, SRC_E1Y, SRC_E1Z, SRC_E2X, SRC_E2Y, SRC_E2Z,
      SRC_TVX, SRC_TVY, SRC_TVZ, SRC_PX, SRC_PY, SRC_PZ,
      SRC_QX, SRC_QY, SRC_QZ, SRC_BEST
   } src_type;

   typedef enum logic [4:0] {
      DST_NONE, DST_E1X, DST_E1Y, DST_E1Z, DST_E2X, DST_E2Y, DST_E2Z,
      DST_TVX, DST_TVY, DST_TVZ, DST_PX, DST_PY, DST_PZ, DST_QX, DST_QY, DST_QZ,
      DST_DET, DST_NUM, DST_U, DST_V, DST_T, DST_HPX, DST_HPY, DST_HPZ
   } dst_type;

   typedef struct packed {
      uop_kind_type kind;
      logic         mul;
      src_type      sa;
      src_type      sb;
      logic         neg;
      logic         first;
      logic         last;
      dst_type      dst;
   } uop_type;

   typedef struct packed {
      logic load;
      logic is_mul;
      logic acc_en;
      logic first;
      logic neg;
   } mac_ctl_type;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(ONE_Q - ONE_Q) + {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
      lo = -hi - ACC_W'(1);
      if (x > hi) return {1'b0, {(WORD_W-1){1'b1}}};
      else if (x < lo) return {1'b1, {(WORD_W-1){1'b0}}};
      else return x[WORD_W-1:0];
   endfunction

   function automatic uop_type tm(input logic mul, input src_type sa, input src_type sb,
                                  input logic neg, input logic first, input logic last,
                                  input dst_type dst);
      uop_type u;
      u.kind = UK_TERM; u.mul = mul; u.sa = sa; u.sb = sb;
      u.neg = neg; u.first = first; u.last = last; u.dst = dst;
      return u;
   endfunction

   function automatic uop_type op(input uop_kind_type kind, input dst_type dst);
      uop_type u;
      u = tm(1'b0, SRC_HX, SRC_HX, 1'b0, 1'b0, 1'b0, dst);
      u.kind = kind;
      return u;
   endfunction

   function automatic uop_type ucode(input logic [STEP_W-1:0] step);
      uop_type u;
      case (step)
         6'd0:  u = tm(0, SRC_AX, SRC_HX, 0, 1, 0, DST_NONE);
         6'd1:  u = tm(0, SRC_HX, SRC_HX, 1, 0, 1, DST_E1X);
         6'd2:  u = tm(0, SRC_AY, SRC_HX, 0, 1, 0, DST_NONE);
         6'd3:  u = tm(0, SRC_HY, SRC_HX, 1, 0, 1, DST_E1Y);
         6'd4:  u = tm(0, SRC_AZ, SRC_HX, 0, 1, 0, DST_NONE);
         6'd5:  u = tm(0, SRC_HZ, SRC_HX, 1, 0, 1, DST_E1Z);
         6'd6:  u = tm(0, SRC_BX, SRC_HX, 0, 1, 0, DST_NONE);
         6'd7:  u = tm(0, SRC_HX, SRC_HX, 1, 0, 1, DST_E2X);
         6'd8:  u = tm(0, SRC_BY, SRC_HX, 0, 1, 0, DST_NONE);
         6'd9:  u = tm(0, SRC_HY, SRC_HX, 1, 0, 1, DST_E2Y);
         6'd10: u = tm(0, SRC_BZ, SRC_HX, 0, 1, 0, DST_NONE);
         6'd11: u = tm(0, SRC_HZ, SRC_HX, 1, 0, 1, DST_E2Z);
         6'd12: u = tm(0, SRC_OX, SRC_HX, 0, 1, 0, DST_NONE);
         6'd13: u = tm(0, SRC_HX, SRC_HX, 1, 0, 1, DST_TVX);
         6'd14: u = tm(0, SRC_OY, SRC_HX, 0, 1, 0, DST_NONE);
         6'd15: u = tm(0, SRC_HY, SRC_HX, 1, 0, 1, DST_TVY);
         6'd16: u = tm(0, SRC_OZ, SRC_HX, 0, 1, 0, DST_NONE);
         6'd17: u = tm(0, SRC_HZ, SRC_HX, 1, 0, 1, DST_TVZ);
         6'd18: u = tm(1, SRC_DY, SRC_E2Z, 0, 1, 0, DST_NONE);
         6'd19: u = tm(1, SRC_DZ, SRC_E2Y, 1, 0, 1, DST_PX);
         6'd20: u = tm(1, SRC_DZ, SRC_E2X, 0, 1, 0, DST_NONE);
         6'd21: u = tm(1, SRC_DX, SRC_E2Z, 1, 0, 1, DST_PY);
         6'd22: u = tm(1, SRC_DX, SRC_E2Y, 0, 1, 0, DST_NONE);
         6'd23: u = tm(1, SRC_DY, SRC_E2X, 1, 0, 1, DST_PZ);
         6'd24: u = tm(1, SRC_E1X, SRC_PX, 0, 1, 0, DST_NONE);
         6'd25: u = tm(1, SRC_E1Y, SRC_PY, 0, 0, 0, DST_NONE);
         6'd26: u = tm(1, SRC_E1Z, SRC_PZ, 0, 0, 1, DST_DET);
         6'd27: u = op(UK_TDET, DST_NONE);
         6'd28: u = tm(1, SRC_TVX, SRC_PX, 0, 1, 0, DST_NONE);
         6'd29: u = tm(1, SRC_TVY, SRC_PY, 0, 0, 0, DST_NONE);
         6'd30: u = tm(1, SRC_TVZ, SRC_PZ, 0, 0, 1, DST_NUM);
         6'd31: u = op(UK_DIV, DST_U);
         6'd32: u = op(UK_TU, DST_NONE);
         6'd33: u = tm(1, SRC_TVY, SRC_E1Z, 0, 1, 0, DST_NONE);
         6'd34: u = tm(1, SRC_TVZ, SRC_E1Y, 1, 0, 1, DST_QX);
         6'd35: u = tm(1, SRC_TVZ, SRC_E1X, 0, 1, 0, DST_NONE);
         6'd36: u = tm(1, SRC_TVX, SRC_E1Z, 1, 0, 1, DST_QY);
         6'd37: u = tm(1, SRC_TVX, SRC_E1Y, 0, 1, 0, DST_NONE);
         6'd38: u = tm(1, SRC_TVY, SRC_E1X, 1, 0, 1, DST_QZ);
         6'd39: u = tm(1, SRC_DX, SRC_QX, 0, 1, 0, DST_NONE);
         6'd40: u = tm(1, SRC_DY, SRC_QY, 0, 0, 0, DST_NONE);
         6'd41: u = tm(1, SRC_DZ, SRC_QZ, 0, 0, 1, DST_NUM);
         6'd42: u = op(UK_DIV, DST_V);
         6'd43: u = op(UK_TV, DST_NONE);
         6'd44: u = tm(1, SRC_E2X, SRC_QX, 0, 1, 0, DST_NONE);
         6'd45: u = tm(1, SRC_E2Y, SRC_QY, 0, 0, 0, DST_NONE);
         6'd46: u = tm(1, SRC_E2Z, SRC_QZ, 0, 0, 1, DST_NUM);
         6'd47: u = op(UK_DIV, DST_T);
         6'd48: u = op(UK_TT, DST_NONE);
         6'd49: u = op(UK_FIN, DST_NONE);
         6'd50: u = tm(0, SRC_OX, SRC_HX, 0, 1, 0, DST_NONE);
         6'd51: u = tm(1, SRC_DX, SRC_BEST, 0, 0, 1, DST_HPX);
         6'd52: u = tm(0, SRC_OY, SRC_HX, 0, 1, 0, DST_NONE);
         6'd53: u = tm(1, SRC_DY, SRC_BEST, 0, 0, 1, DST_HPY);
         6'd54: u = tm(0, SRC_OZ, SRC_HX, 0, 1, 0, DST_NONE);
         6'd55: u = tm(1, SRC_DZ, SRC_BEST, 0, 0, 1, DST_HPZ);
         6'd56: u = op(UK_OUT, DST_NONE);
         default: u = op(UK_FIN, DST_NONE);
      endcase
      return u;
   endfunction

endpackage

// ===== rtl/core/nrth_mac.sv =====
// Shared multiply-accumulate unit; the running sum is kept wide and its result is saturated to signed 32 bits.
module nrth_mac (
   input  logic                             clock,
   input  nrth_pkg::mac_ctl_type            ctl,
   input  logic signed [nrth_pkg::WORD_W-1:0] op_a,
   input  logic signed [nrth_pkg::WORD_W-1:0] op_b,
   output logic signed [nrth_pkg::WORD_W-1:0] res
);
   import nrth_pkg::*;

   logic signed [2*WORD_W-1:0] prod;
   logic signed [TERM_W-1:0]   term_in, term_ff;
   logic signed [ACC_W-1:0]    term_ext, acc_base, acc_in, acc_ff;

   assign prod    = op_a * op_b;
   assign term_in = ctl.is_mul ? prod[2*WORD_W-1:FRAC_BITS]
                               : {{(TERM_W-WORD_W){op_a[WORD_W-1]}}, op_a};

   assign term_ext = {{(ACC_W-TERM_W){term_ff[TERM_W-1]}}, term_ff};
   assign acc_base = ctl.first ? '0 : acc_ff;
   assign acc_in   = ctl.neg ? acc_base - term_ext : acc_base + term_ext;
   assign res      = sat_word(acc_in);

   always_ff @(posedge clock) begin
      if (ctl.load) term_ff <= term_in;
      if (ctl.acc_en) acc_ff <= acc_in;
   end

endmodule

// ===== rtl/core/nrth_div.sv =====
// Radix-2 restoring divider for (num * ONE) / den, truncated and saturated to 32 bits.
module nrth_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [nrth_pkg::WORD_W-1:0] num,
   input  logic signed [nrth_pkg::WORD_W-1:0] den,
   output logic                               done,
   output logic signed [nrth_pkg::WORD_W-1:0] quo
);
   import nrth_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);

   logic [WORD_W-1:0]  num_mag, den_mag;
   logic [DVD_W-1:0]   qd_ff, qd_in;
   logic [WORD_W-1:0]  rem_ff, rem_in, dvs_ff;
   logic [WORD_W:0]    rem_sh;
   logic [WORD_W+1:0]  diff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in, fin_ff, fin_in, done_ff, done_in, neg_ff;
   logic signed [WORD_W-1:0] quo_ff, quo_in;

   assign num_mag = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
   assign den_mag = den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);

   assign rem_sh = {rem_ff, qd_ff[DVD_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};

   always_comb begin
      rem_in = rem_ff;
      qd_in  = qd_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      fin_in = 1'b0;
      done_in = 1'b0;
      quo_in = quo_ff;
      if (start) begin
         rem_in = '0;
         qd_in  = {num_mag, {FRAC_BITS{1'b0}}};
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[WORD_W+1]) begin
            rem_in = diff[WORD_W-1:0];
            qd_in  = {qd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[WORD_W-1:0];
            qd_in  = {qd_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (!neg_ff) begin
            if (qd_ff > DVD_W'({1'b0, {(WORD_W-1){1'b1}}})) quo_in = {1'b0, {(WORD_W-1){1'b1}}};
            else quo_in = qd_ff[WORD_W-1:0];
         end else begin
            if (qd_ff > DVD_W'({1'b1, {(WORD_W-1){1'b0}}})) quo_in = {1'b1, {(WORD_W-1){1'b0}}};
            else quo_in = -qd_ff[WORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      qd_ff  <= qd_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= den_mag;
         neg_ff <= num[WORD_W-1] ^ den[WORD_W-1];
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/core/nearest_ray_triangle_hit_unit.sv =====
// Top level: micro-sequenced nearest ray/triangle hit search over a shared MAC and divider.
//
//   channel | ports                       | width  | direction
//   req     | req_valid/req_ready/req_data | 305    | in, one triangle per word
//   rsp     | rsp_valid/rsp_ready/rsp_data | 144    | out, one word per last triangle
//   csr     | csr_we/csr_index/csr_wdata   | 3 + 32 | in, write only
//
// A triangle with a zero determinant skips all three divisions; otherwise up to three
// divisions run on the radix-2 divider, and every sum term passes through the ST_EXEC
// and ST_ACC states on the single multiplier.
// Reset is synchronous; no clearing pass is needed.
// A result word waits in an output register, so the next triangle is taken while
// rsp_ready is low; only the next result waits for that register to drain.
module nearest_ray_triangle_hit_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  nrth_pkg::req_word_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output nrth_pkg::rsp_word_type        rsp_data,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [nrth_pkg::WORD_W-1:0]   csr_wdata
);
   import nrth_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_ACC  = 4'b0100,
      ST_DIV  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   uop_type uop;

   req_word_type req_ff;
   logic signed [WORD_W-1:0] org_ff [3];
   logic signed [DIR_W-1:0]  dir_ff [3];
   logic [DIST_W-1:0]        start_ff;

   logic signed [WORD_W-1:0] e1_ff [3];
   logic signed [WORD_W-1:0] e2_ff [3];
   logic signed [WORD_W-1:0] tv_ff [3];
   logic signed [WORD_W-1:0] p_ff [3];
   logic signed [WORD_W-1:0] q_ff [3];
   logic signed [WORD_W-1:0] hp_ff [3];
   logic signed [WORD_W-1:0] det_ff, num_ff, u_ff, v_ff, t_ff;

   logic [DIST_W-1:0] best_ff;
   logic [ID_W-1:0]   owner_ff;
   logic              hit_ff;

   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff;

   mac_ctl_type mac_ctl;
   logic signed [WORD_W-1:0] op_a, op_b, mac_res, div_quo, wb_val;
   logic div_start, div_done, wb_en, upd_best, rsp_load;
   logic pass_u, pass_v, pass_t;
   logic signed [WORD_W:0] uv_sum;
   logic [DIST_W-1:0] thr;

   function automatic logic signed [WORD_W-1:0] pick(input src_type s);
      logic signed [WORD_W-1:0] r;
      case (s)
         SRC_HX:   r = req_ff.hub_x;
         SRC_HY:   r = req_ff.hub_y;
         SRC_HZ:   r = req_ff.hub_z;
         SRC_AX:   r = req_ff.first_x;
         SRC_AY:   r = req_ff.first_y;
         SRC_AZ:   r = req_ff.first_z;
         SRC_BX:   r = req_ff.second_x;
         SRC_BY:   r = req_ff.second_y;
         SRC_BZ:   r = req_ff.second_z;
         SRC_OX:   r = org_ff[0];
         SRC_OY:   r = org_ff[1];
         SRC_OZ:   r = org_ff[2];
         SRC_DX:   r = WORD_W'(dir_ff[0]);
         SRC_DY:   r = WORD_W'(dir_ff[1]);
         SRC_DZ:   r = WORD_W'(dir_ff[2]);
         SRC_E1X:  r = e1_ff[0];
         SRC_E1Y:  r = e1_ff[1];
         SRC_E1Z:  r = e1_ff[2];
         SRC_E2X:  r = e2_ff[0];
         SRC_E2Y:  r = e2_ff[1];
         SRC_E2Z:  r = e2_ff[2];
         SRC_TVX:  r = tv_ff[0];
         SRC_TVY:  r = tv_ff[1];
         SRC_TVZ:  r = tv_ff[2];
         SRC_PX:   r = p_ff[0];
         SRC_PY:   r = p_ff[1];
         SRC_PZ:   r = p_ff[2];
         SRC_QX:   r = q_ff[0];
         SRC_QY:   r = q_ff[1];
         SRC_QZ:   r = q_ff[2];
         SRC_BEST: r = {1'b0, best_ff};
         default:  r = '0;
      endcase
      return r;
   endfunction

   assign uop  = ucode(step_ff);

   always_comb begin
      op_a = pick(uop.sa);
      op_b = pick(uop.sb);
   end

   nrth_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .res   (mac_res)
   );

   nrth_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (det_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign uv_sum = {u_ff[WORD_W-1], u_ff} + {v_ff[WORD_W-1], v_ff};
   assign thr    = hit_ff ? best_ff : start_ff;
   assign pass_u = (u_ff > 0) && (u_ff < ONE_Q);
   assign pass_v = (v_ff > 0) && (uv_sum < (WORD_W+1)'(ONE_Q));
   assign pass_t = (t_ff > 0) && (t_ff[DIST_W-1:0] < thr);

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      mac_ctl   = '{load: 1'b0, is_mul: uop.mul, acc_en: 1'b0, first: uop.first, neg: uop.neg};
      div_start = 1'b0;
      wb_en     = 1'b0;
      wb_val    = mac_res;
      upd_best  = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
               step_in  = '0;
            end
         end
         ST_EXEC: begin
            case (uop.kind)
               UK_TERM: begin
                  mac_ctl.load = 1'b1;
                  state_in = ST_ACC;
               end
               UK_DIV: begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
               UK_TDET: step_in = (det_ff == 0) ? STEP_FIN : step_ff + STEP_W'(1);
               UK_TU:   step_in = pass_u ? step_ff + STEP_W'(1) : STEP_FIN;
               UK_TV:   step_in = pass_v ? step_ff + STEP_W'(1) : STEP_FIN;
               UK_TT: begin
                  upd_best = pass_t;
                  step_in  = STEP_FIN;
               end
               UK_FIN: begin
                  if (req_ff.last_triangle) step_in = STEP_POINT;
                  else state_in = ST_IDLE;
               end
               UK_OUT: begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ACC: begin
            mac_ctl.acc_en = 1'b1;
            wb_en    = uop.last;
            step_in  = step_ff + STEP_W'(1);
            state_in = ST_EXEC;
         end
         ST_DIV: begin
            if (div_done) begin
               wb_en    = 1'b1;
               wb_val   = div_quo;
               step_in  = step_ff + STEP_W'(1);
               state_in = ST_EXEC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         org_ff[0]    <= '0;
         org_ff[1]    <= '0;
         org_ff[2]    <= '0;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= '0;
         dir_ff[2]    <= DIR_W'(ONE_Q);
         start_ff     <= START_RESET;
         best_ff      <= START_RESET;
         owner_ff     <= '0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ORIGIN_X:       org_ff[0] <= csr_wdata;
               CSR_ORIGIN_Y:       org_ff[1] <= csr_wdata;
               CSR_ORIGIN_Z:       org_ff[2] <= csr_wdata;
               CSR_DIR_X:          dir_ff[0] <= csr_wdata[DIR_W-1:0];
               CSR_DIR_Y:          dir_ff[1] <= csr_wdata[DIR_W-1:0];
               CSR_DIR_Z:          dir_ff[2] <= csr_wdata[DIR_W-1:0];
               CSR_START_DISTANCE: start_ff  <= csr_wdata[DIST_W-1:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            best_ff  <= start_ff;
            owner_ff <= '0;
            hit_ff   <= 1'b0;
         end else if (upd_best) begin
            best_ff  <= t_ff[DIST_W-1:0];
            owner_ff <= req_ff.hub_id;
            hit_ff   <= 1'b1;
         end
      end
      if (req_valid && req_ready) req_ff <= req_data;
      if (rsp_load) begin
         rsp_ff.found      <= hit_ff;
         rsp_ff.nearest_id <= hit_ff ? owner_ff : '0;
         rsp_ff.hit_t      <= hit_ff ? best_ff : '0;
         rsp_ff.point_x    <= hit_ff ? hp_ff[0] : '0;
         rsp_ff.point_y    <= hit_ff ? hp_ff[1] : '0;
         rsp_ff.point_z    <= hit_ff ? hp_ff[2] : '0;
      end
      if (wb_en) begin
         case (uop.dst)
            DST_E1X: e1_ff[0] <= wb_val;
            DST_E1Y: e1_ff[1] <= wb_val;
            DST_E1Z: e1_ff[2] <= wb_val;
            DST_E2X: e2_ff[0] <= wb_val;
            DST_E2Y: e2_ff[1] <= wb_val;
            DST_E2Z: e2_ff[2] <= wb_val;
            DST_TVX: tv_ff[0] <= wb_val;
            DST_TVY: tv_ff[1] <= wb_val;
            DST_TVZ: tv_ff[2] <= wb_val;
            DST_PX:  p_ff[0]  <= wb_val;
            DST_PY:  p_ff[1]  <= wb_val;
            DST_PZ:  p_ff[2]  <= wb_val;
            DST_QX:  q_ff[0]  <= wb_val;
            DST_QY:  q_ff[1]  <= wb_val;
            DST_QZ:  q_ff[2]  <= wb_val;
            DST_DET: det_ff   <= wb_val;
            DST_NUM: num_ff   <= wb_val;
            DST_U:   u_ff     <= wb_val;
            DST_V:   v_ff     <= wb_val;
            DST_T:   t_ff     <= wb_val;
            DST_HPX: hp_ff[0] <= wb_val;
            DST_HPY: hp_ff[1] <= wb_val;
            DST_HPZ: hp_ff[2] <= wb_val;
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/nrth_checker.sv =====
// Port-level checks for the nearest ray/triangle hit unit and their bind.
module nrth_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input nrth_pkg::rsp_word_type rsp_data
);
   import nrth_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed or dropped while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.nearest_id == 0 && rsp_data.hit_t == 0 &&
      rsp_data.point_x == 0 && rsp_data.point_y == 0 && rsp_data.point_z == 0)
      else $error("miss word carries nonzero fields");

   a_hit_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.hit_t != 0)
      else $error("hit word with zero distance");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new word taken right after accept");

endmodule

bind nearest_ray_triangle_hit_unit nrth_checker u_nrth_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
